### hdl/dpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debug packet deframer package
// Shared types, character codes, event codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 256;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_HI   = 2'd2,
    PH_LO   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_START   = 3'd0,
    EV_DATA    = 3'd1,
    EV_RESTART = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BAD     = 3'd4
  } event_t;

  typedef struct packed {
    logic       valid;
    event_t     event_res;
    logic [7:0] data_byte;
    logic [8:0] packet_length;
    logic [7:0] computed_sum;
    logic       overflow;
    logic       send_nack;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    case (b) inside
      [8'h30:8'h39]: h.value = b[3:0];
      [8'h61:8'h66],
      [8'h41:8'h46]: h.value = b[3:0] + 4'd9;
      default:       h.ok    = 1'b0;
    endcase
    return h;
  endfunction

endpackage

### hdl/dpd_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame tracker
// Phase state machine, running sum, saturating length and checksum compare.
// ----------------------------------------------------------------------------
module dpd_frame_fsm #(
  parameter int unsigned MAX_PAYLOAD = dpd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,      // consume rx_byte this cycle
  input  logic [7:0]       rx_byte,
  output dpd_pkg::result_t result     // valid only meaningful with step
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD);

  dpd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [3:0]      hi_r, hi_nxt;
  logic            bad_digit_r, bad_digit_nxt;
  logic            ovf_r, ovf_nxt;

  dpd_pkg::hex_t   hex;
  logic [CW+8:0]   cnt_ext;
  logic [7:0]      rx_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dpd_pkg::PH_IDLE;
      sum_r       <= 8'd0;
      cnt_r       <= '0;
      hi_r        <= 4'd0;
      bad_digit_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      hi_r        <= hi_nxt;
      bad_digit_r <= bad_digit_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_comb begin
    hex           = dpd_pkg::hex_decode(rx_byte);
    rx_sum        = {hi_r, hex.value};
    phase_nxt     = phase_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    hi_nxt        = hi_r;
    bad_digit_nxt = bad_digit_r;
    ovf_nxt       = ovf_r;
    result        = '0;
    result.event_res = dpd_pkg::EV_START;

    case (phase_r)
      dpd_pkg::PH_IDLE: begin
        if (rx_byte == dpd_pkg::CH_START) begin
          sum_nxt   = 8'd0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          phase_nxt = dpd_pkg::PH_DATA;
          result.valid     = 1'b1;
          result.event_res = dpd_pkg::EV_START;
        end
      end
      dpd_pkg::PH_DATA: begin
        if (rx_byte == dpd_pkg::CH_START) begin
          sum_nxt = 8'd0;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
          result.valid     = 1'b1;
          result.event_res = dpd_pkg::EV_RESTART;
        end else if (rx_byte == dpd_pkg::CH_END) begin
          phase_nxt = dpd_pkg::PH_HI;
        end else begin
          sum_nxt = sum_r + rx_byte;
          // saturate the length and flag the overrun
          if (cnt_r < CNT_MAX) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          result.valid     = 1'b1;
          result.event_res = dpd_pkg::EV_DATA;
          result.data_byte = rx_byte;
        end
      end
      dpd_pkg::PH_HI: begin
        hi_nxt        = hex.value;
        bad_digit_nxt = ~hex.ok;
        phase_nxt     = dpd_pkg::PH_LO;
      end
      dpd_pkg::PH_LO: begin
        phase_nxt    = dpd_pkg::PH_IDLE;
        result.valid = 1'b1;
        if (hex.ok && !bad_digit_r && rx_sum == sum_r) begin
          result.event_res = dpd_pkg::EV_GOOD;
        end else begin
          result.event_res = dpd_pkg::EV_BAD;
          result.send_nack = 1'b1;
        end
      end
      default: phase_nxt = dpd_pkg::PH_IDLE;
    endcase

    // report the updated packet totals
    cnt_ext              = {9'd0, cnt_nxt};
    result.packet_length = cnt_ext[8:0];
    result.computed_sum  = sum_nxt;
    result.overflow      = ovf_nxt;
  end

endmodule

### hdl/debug_packet_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debug packet deframer core
// Frames '$' payload '#' hh packets from a serial byte stream.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata (low bit up)                          | tuser
//   --------+-----+---------------------------------------------+-----------
//   in_     | in  | rx_byte[7:0]                                | -
//   out_    | out | data_byte, packet_length, computed_sum,     | event_res
//           |     | overflow, send_nack, zero pad to 32 bits    |
//
// One beat per cycle sustained while out_tready stays high; a result beat passes
// from the input register, which loads when its byte is accepted, to the result
// register, which drives out_.
// The frame tracker updates its state in the cycle the input register drains,
// so its state loop sets the rate.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
// A stall on out_tready holds the result register and, through it, in_tready.
// ----------------------------------------------------------------------------
module debug_packet_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = dpd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [16:8] packet_length,
                                  // [24:17] computed_sum, [25] overflow,
                                  // [26] send_nack, [31:27] zero
  output logic [2:0]  out_tuser   // [2:0] event_res
);

  // Input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;

  // Result register
  logic       out_vld_r, out_vld_nxt;
  dpd_pkg::result_t res_r;
  dpd_pkg::result_t res_comb;

  logic advance;   // input register drains into the tracker
  logic out_free;  // result register can take a new beat

  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  dpd_frame_fsm #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .rx_byte(in_byte_r),
    .result (res_comb)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
    end
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      // drop beats that produce no result
      out_vld_nxt = advance && res_comb.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: load on accept, hold on stall
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance && out_free) begin
      res_r <= res_comb;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.event_res;
  assign out_tdata  = {5'd0, res_r.send_nack, res_r.overflow, res_r.computed_sum,
                       res_r.packet_length, res_r.data_byte};

endmodule
